// ===== rtl/spb_pkg.sv =====
// Shared constants for the spectrum peak and bar block.
// No dependencies; used by every module of the block.
package spb_pkg;

  // FFT length, a power of two; the peak frequency is index * rate >> log2
  localparam int unsigned FFT_POINTS   = 256;
  localparam int unsigned FFT_LOG2     = $clog2(FFT_POINTS);
  localparam int unsigned BINS_SCANNED = 64;

  localparam int unsigned IDX_W  = 6;
  localparam int unsigned MAG_W  = 29;
  localparam int unsigned RATE_W = 24;
  localparam int unsigned BAR_W  = 8;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned ROOT_W = 16;
  localparam int unsigned PROD_W = IDX_W + RATE_W;

  localparam logic [IDX_W-1:0] LAST_BIN  = IDX_W'(BINS_SCANNED - 1);
  localparam logic [BAR_W-1:0] BAR_BASE  = 8'd240;
  localparam logic [MAG_W-1:0] BAR_LIMIT = MAG_W'(60);

  // one root digit per cycle
  localparam int unsigned SQRT_STEPS = SUM_W / 2;
  localparam int unsigned SQRT_CNT_W = $clog2(SQRT_STEPS);

  // configuration register indexes
  localparam logic REG_MAGNITUDE_MODE = 1'b0;
  localparam logic REG_SAMPLE_RATE    = 1'b1;

  // magnitude modes
  localparam logic MODE_ROOT  = 1'b0;
  localparam logic MODE_POWER = 1'b1;

endpackage

// ===== rtl/spb_isqrt.sv =====
// Iterative integer square root of a 32-bit word, one result bit per cycle.
// Uses spb_pkg for widths and step count.
module spb_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [spb_pkg::SUM_W-1:0]    radicand_i,
  output logic                         done_o,
  output logic [spb_pkg::ROOT_W-1:0]   root_o
);

  logic [spb_pkg::SUM_W-1:0]      rad_q;
  logic [spb_pkg::ROOT_W:0]       rem_q;
  logic [spb_pkg::ROOT_W-1:0]     root_q;
  logic [spb_pkg::SQRT_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  logic [spb_pkg::ROOT_W+2:0] rem_sh;
  logic [spb_pkg::ROOT_W+2:0] trial;
  logic [spb_pkg::ROOT_W+2:0] diff;
  logic                       ge;

  // bring down the next bit pair and try the digit one
  assign rem_sh = {rem_q, rad_q[spb_pkg::SUM_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rad_q  <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rad_q  <= rad_q << 2;
        rem_q  <= ge ? diff[spb_pkg::ROOT_W:0] : rem_sh[spb_pkg::ROOT_W:0];
        root_q <= {root_q[spb_pkg::ROOT_W-2:0], ge};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == spb_pkg::SQRT_CNT_W'(spb_pkg::SQRT_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/spectrum_peak_and_bars.sv =====
// From accept to result: square both parts, form the magnitude, take the root in root
// mode (not in power mode or on bin 0), update the peak, and on the last bin of a
// frame form the frequency product. One word is processed at a time; the 16-step
// square root sets the pace in root mode. A result waits in the output register while
// the next word is taken; a second finished result stalls the input until it drains.
// Reset (rst_ni, asynchronous, active low) clears the counter, the peak and the config.
module spectrum_peak_and_bars (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [spb_pkg::RATE_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [15:0]                  bin_real_i,
  input  logic signed [15:0]                  bin_imag_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [spb_pkg::IDX_W-1:0]           bin_index_o,
  output logic                                bin_used_o,
  output logic [spb_pkg::MAG_W-1:0]           bin_magnitude_o,
  output logic [spb_pkg::BAR_W-1:0]           bar_top_row_o,
  output logic                                frame_done_o,
  output logic [spb_pkg::IDX_W-1:0]           peak_index_o,
  output logic [spb_pkg::MAG_W-1:0]           peak_amplitude_o,
  output logic [spb_pkg::RATE_W-1:0]          peak_freq_hz_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ_RE, S_SQ_IM, S_MAG, S_ROOT, S_UPD, S_FREQ, S_DONE
  } state_e;

  state_e state_q;

  logic                          mode_q;
  logic [spb_pkg::RATE_W-1:0]    rate_q;

  logic [spb_pkg::IDX_W-1:0]     bin_cnt_q;
  logic [spb_pkg::MAG_W-1:0]     best_mag_q;
  logic [spb_pkg::IDX_W-1:0]     best_bin_q;

  logic [15:0]                   re_abs_q;
  logic [15:0]                   im_abs_q;
  logic [spb_pkg::SUM_W-1:0]     sum_q;
  logic [spb_pkg::MAG_W-1:0]     mag_q;
  logic                          last_q;
  logic [spb_pkg::IDX_W-1:0]     pk_idx_q;
  logic [spb_pkg::MAG_W-1:0]     pk_amp_q;
  logic [spb_pkg::RATE_W-1:0]    freq_q;

  logic                          out_valid_q;
  logic [spb_pkg::IDX_W-1:0]     out_idx_q;
  logic                          out_used_q;
  logic [spb_pkg::MAG_W-1:0]     out_mag_q;
  logic [spb_pkg::BAR_W-1:0]     out_bar_q;
  logic                          out_last_q;
  logic [spb_pkg::IDX_W-1:0]     out_pk_idx_q;
  logic [spb_pkg::MAG_W-1:0]     out_pk_amp_q;
  logic [spb_pkg::RATE_W-1:0]    out_freq_q;

  logic                          used;
  logic                          last;
  logic [15:0]                   mul_a;
  logic [spb_pkg::SUM_W-1:0]     square;
  logic [spb_pkg::PROD_W-1:0]    freq_prod;
  logic [spb_pkg::PROD_W-1:0]    freq_scaled;
  logic                          take_best;
  logic [spb_pkg::MAG_W-1:0]     nb_mag;
  logic [spb_pkg::IDX_W-1:0]     nb_bin;
  logic [spb_pkg::BAR_W-1:0]     bar_val;
  logic                          sq_start;
  logic                          sq_done;
  logic [spb_pkg::ROOT_W-1:0]    sq_root;
  logic                          out_free;

  assign used = bin_cnt_q != '0;
  assign last = bin_cnt_q >= spb_pkg::LAST_BIN;

  // shared squarer: real part first, then imaginary
  assign mul_a  = (state_q == S_SQ_RE) ? re_abs_q : im_abs_q;
  assign square = mul_a * mul_a;

  assign freq_prod   = pk_idx_q * rate_q;
  assign freq_scaled = freq_prod >> spb_pkg::FFT_LOG2;

  // strict compare keeps the first of equal peaks
  assign take_best = used && (mag_q > best_mag_q);
  assign nb_mag    = take_best ? mag_q : best_mag_q;
  assign nb_bin    = take_best ? bin_cnt_q : best_bin_q;

  assign bar_val = !used ? spb_pkg::BAR_BASE :
                   (mag_q >= spb_pkg::BAR_LIMIT) ? '0 :
                   spb_pkg::BAR_BASE - {mag_q[5:0], 2'b00};

  assign sq_start = (state_q == S_MAG) && used && (mode_q == spb_pkg::MODE_ROOT);
  assign out_free = !out_valid_q || out_ready_i;

  spb_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sum_q),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b0;
      rate_q      <= '0;
      bin_cnt_q   <= '0;
      best_mag_q  <= '0;
      best_bin_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          spb_pkg::REG_MAGNITUDE_MODE: mode_q <= cfg_data_i[0];
          spb_pkg::REG_SAMPLE_RATE:    rate_q <= cfg_data_i;
          default: ;
        endcase
      end

      // drop the taken word unless a new one is loaded this cycle
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            re_abs_q <= bin_real_i[15] ? 16'(-bin_real_i) : 16'(bin_real_i);
            im_abs_q <= bin_imag_i[15] ? 16'(-bin_imag_i) : 16'(bin_imag_i);
            state_q  <= S_SQ_RE;
          end
        end
        S_SQ_RE: begin
          sum_q   <= square;
          state_q <= S_SQ_IM;
        end
        S_SQ_IM: begin
          sum_q   <= sum_q + square;
          state_q <= S_MAG;
        end
        S_MAG: begin
          if (!used) begin
            mag_q   <= '0;
            state_q <= S_UPD;
          end else if (mode_q == spb_pkg::MODE_POWER) begin
            mag_q   <= spb_pkg::MAG_W'(sum_q >> 3);
            state_q <= S_UPD;
          end else begin
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            mag_q   <= spb_pkg::MAG_W'(sq_root >> 3) + spb_pkg::MAG_W'(1);
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          last_q <= last;
          if (last) begin
            pk_idx_q   <= nb_bin;
            pk_amp_q   <= nb_mag;
            best_mag_q <= '0;
            best_bin_q <= '0;
            state_q    <= S_FREQ;
          end else begin
            pk_idx_q   <= '0;
            pk_amp_q   <= '0;
            freq_q     <= '0;
            best_mag_q <= nb_mag;
            best_bin_q <= nb_bin;
            state_q    <= S_DONE;
          end
        end
        S_FREQ: begin
          freq_q  <= freq_scaled[spb_pkg::RATE_W-1:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_idx_q    <= bin_cnt_q;
            out_used_q   <= used;
            out_mag_q    <= mag_q;
            out_bar_q    <= bar_val;
            out_last_q   <= last_q;
            out_pk_idx_q <= pk_idx_q;
            out_pk_amp_q <= pk_amp_q;
            out_freq_q   <= freq_q;
            state_q      <= S_IDLE;
            if (last_q) begin
              bin_cnt_q <= '0;
            end else begin
              bin_cnt_q <= bin_cnt_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // bin index and bar are taken from the counter before it advances
  assign in_ready_o       = state_q == S_IDLE;
  assign out_valid_o      = out_valid_q;
  assign bin_index_o      = out_idx_q;
  assign bin_used_o       = out_used_q;
  assign bin_magnitude_o  = out_mag_q;
  assign bar_top_row_o    = out_bar_q;
  assign frame_done_o     = out_last_q;
  assign peak_index_o     = out_pk_idx_q;
  assign peak_amplitude_o = out_pk_amp_q;
  assign peak_freq_hz_o   = out_freq_q;

`ifndef SYNTH
  a_unused_bin_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bin_used_o |-> bin_magnitude_o == '0 &&
      bar_top_row_o == spb_pkg::BAR_BASE)
    else $error("ignored bin carries a magnitude or a bar");

  a_peak_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> peak_amplitude_o == '0 && peak_index_o == '0 &&
      peak_freq_hz_o == '0)
    else $error("peak fields set before the last bin");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD && last |=> best_mag_q == '0 && best_bin_q == '0)
    else $error("frame state not cleared after the last bin");

  a_root_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == S_ROOT)
    else $error("root result arrived outside the root wait");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for spectrum_peak_and_bars: FFT bin words in, one bin result out.
// Expected results come from an in-bench predictor; depends on rtl/spb_pkg.sv and the block.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [spb_pkg::RATE_W-1:0] RATE_MAX = '1;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
  } bin_word_t;

  typedef struct packed {
    logic [spb_pkg::IDX_W-1:0]  index;
    logic                       used;
    logic [spb_pkg::MAG_W-1:0]  magnitude;
    logic [spb_pkg::BAR_W-1:0]  bar;
    logic                       done;
    logic [spb_pkg::IDX_W-1:0]  pk_index;
    logic [spb_pkg::MAG_W-1:0]  pk_amp;
    logic [spb_pkg::RATE_W-1:0] pk_freq;
  } bin_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic                         cfg_index_i = spb_pkg::REG_MAGNITUDE_MODE;
  logic [spb_pkg::RATE_W-1:0]   cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic signed [15:0]           bin_real_i = '0;
  logic signed [15:0]           bin_imag_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [spb_pkg::IDX_W-1:0]    bin_index_o;
  logic                         bin_used_o;
  logic [spb_pkg::MAG_W-1:0]    bin_magnitude_o;
  logic [spb_pkg::BAR_W-1:0]    bar_top_row_o;
  logic                         frame_done_o;
  logic [spb_pkg::IDX_W-1:0]    peak_index_o;
  logic [spb_pkg::MAG_W-1:0]    peak_amplitude_o;
  logic [spb_pkg::RATE_W-1:0]   peak_freq_hz_o;

  spectrum_peak_and_bars dut (.*);

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // predictor copy of configuration and frame state
  logic                       cfg_mode;
  logic [spb_pkg::RATE_W-1:0] cfg_rate;
  logic [spb_pkg::IDX_W-1:0]  frame_pos;
  logic [spb_pkg::MAG_W-1:0]  peak_mag;
  logic [spb_pkg::IDX_W-1:0]  peak_bin;

  bin_word_t   pending_bins[$];
  bin_result_t expected_bins[$];

  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned hold_left = 0;
  bit          hold_started = 1'b0;
  bin_word_t   next_word;
  bin_result_t got_bin;
  bin_result_t want_bin;

  function automatic logic [15:0] root_of(longint v);
    logic [15:0] root;
    logic [15:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      if (longint'(trial) * longint'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  function automatic bin_result_t score_bin(logic signed [15:0] re, logic signed [15:0] im);
    bin_result_t r;
    longint      sq;
    longint      prod;
    logic [spb_pkg::MAG_W-1:0] mag;
    r = '0;
    sq = longint'(re) * longint'(re) + longint'(im) * longint'(im);
    r.index = frame_pos;
    r.used = frame_pos != 0;
    r.bar = spb_pkg::BAR_BASE;
    if (r.used) begin
      if (cfg_mode == spb_pkg::MODE_POWER) mag = spb_pkg::MAG_W'(sq >> 3);
      else mag = spb_pkg::MAG_W'(root_of(sq) >> 3) + spb_pkg::MAG_W'(1);
      r.magnitude = mag;
      if (mag >= spb_pkg::BAR_LIMIT) r.bar = '0;
      else r.bar = spb_pkg::BAR_W'(int'(spb_pkg::BAR_BASE) - 4 * int'(mag));
      // strict compare: the first of equal peaks stays
      if (mag > peak_mag) begin
        peak_mag = mag;
        peak_bin = frame_pos;
      end
    end
    if (frame_pos == spb_pkg::LAST_BIN) begin
      prod = longint'(peak_bin) * longint'(cfg_rate);
      r.done = 1'b1;
      r.pk_index = peak_bin;
      r.pk_amp = peak_mag;
      r.pk_freq = spb_pkg::RATE_W'(prod / longint'(spb_pkg::FFT_POINTS));
      frame_pos = '0;
      peak_mag = '0;
      peak_bin = '0;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // driver: offer queued words, predict on accept
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      bin_real_i <= '0;
      bin_imag_i <= '0;
      tx_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_bins.push_back(score_bin(bin_real_i, bin_imag_i));
        words_sent <= words_sent + 1;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (tx_gap != 0) begin
          in_valid_i <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (pending_bins.size() != 0) begin
          next_word = pending_bins.pop_front();
          in_valid_i <= 1'b1;
          bin_real_i <= next_word.re;
          bin_imag_i <= next_word.im;
          if (tx_idle_on && $urandom_range(0, 3) == 0) tx_gap <= $urandom_range(1, 15);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off while words keep coming
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_started <= 1'b0;
    end else if (!hold_started && words_sent >= 300 && pending_bins.size() > 20) begin
      hold_left <= HOLD_CYCLES;
      hold_started <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_bin = '{bin_index_o, bin_used_o, bin_magnitude_o, bar_top_row_o,
                    frame_done_o, peak_index_o, peak_amplitude_o, peak_freq_hz_o};
        if (expected_bins.size() == 0) begin
          $error("result with no expectation: bin_index %0d", bin_index_o);
          fail_count++;
        end else begin
          want_bin = expected_bins.pop_front();
          check_field("bin_index", want_bin.index, got_bin.index);
          check_field("bin_used", want_bin.used, got_bin.used);
          check_field("bin_magnitude", want_bin.magnitude, got_bin.magnitude);
          check_field("bar_top_row", want_bin.bar, got_bin.bar);
          check_field("frame_done", want_bin.done, got_bin.done);
          check_field("peak_index", want_bin.pk_index, got_bin.pk_index);
          check_field("peak_amplitude", want_bin.pk_amp, got_bin.pk_amp);
          check_field("peak_freq_hz", want_bin.pk_freq, got_bin.pk_freq);
        end
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (rx_stall != 0) begin
        out_ready_i <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        rx_stall <= $urandom_range(0, 14);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // stimulus generation
  int unsigned gen_pos = 0;
  bit          quiet_frame = 1'b0;
  bin_word_t   last_word = '0;

  task automatic queue_one(int re, int im);
    bin_word_t w;
    w.re = 16'(re);
    w.im = 16'(im);
    pending_bins.push_back(w);
    last_word = w;
    gen_pos = (gen_pos + 1) % spb_pkg::BINS_SCANNED;
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  task automatic queue_random(int unsigned n);
    int unsigned style;
    int          sgn;
    repeat (n) begin
      // start of a frame: sometimes make the whole frame near zero
      if (gen_pos == 0) quiet_frame = $urandom_range(0, 5) == 0;
      if (quiet_frame) begin
        queue_one($urandom_range(0, 2) - 1, $urandom_range(0, 2) - 1);
      end else begin
        style = $urandom_range(0, 9);
        sgn = $urandom_range(0, 1) ? -1 : 1;
        case (style)
          0, 1, 2, 3: queue_one(int'($signed(16'($urandom))), int'($signed(16'($urandom))));
          4: queue_one($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20);
          5, 6: queue_one($urandom_range(0, 1200) - 600, $urandom_range(0, 1200) - 600);
          7: queue_one(pick_extreme(), pick_extreme());
          8: queue_one(int'($signed(last_word.re)), int'($signed(last_word.im)));
          default: queue_one(sgn * (1 << $urandom_range(0, 14)), $urandom_range(0, 3) - 1);
        endcase
      end
    end
  endtask

  task automatic write_config(logic mode, logic [spb_pkg::RATE_W-1:0] rate);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= spb_pkg::REG_MAGNITUDE_MODE;
    cfg_data_i <= spb_pkg::RATE_W'(mode);
    cfg_mode = mode;
    @(posedge clk_i);
    cfg_index_i <= spb_pkg::REG_SAMPLE_RATE;
    cfg_data_i <= rate;
    cfg_rate = rate;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sample at the falling edge so the driver's updates have settled
  task automatic drain();
    while (pending_bins.size() != 0 || expected_bins.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned total;
    int unsigned phase;
    int unsigned n;
    logic [spb_pkg::RATE_W-1:0] rate;
    cfg_mode = spb_pkg::MODE_ROOT;
    cfg_rate = '0;
    frame_pos = '0;
    peak_mag = '0;
    peak_bin = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_config(spb_pkg::MODE_ROOT, RATE_MAX);
    // bin 0 is ignored even at full scale
    queue_one(-32768, -32768);
    queue_one(-32768, -32768);
    queue_one(32767, 32767);
    queue_one(0, 0);
    queue_one(-32768, 0);
    queue_one(0, -32768);
    queue_one(32767, -32768);
    queue_one(-1, -1);
    // bar just above and at the clamp
    queue_one(471, 0);
    queue_one(472, 0);
    // tie with the earlier full-scale peak
    queue_one(-32768, -32768);
    queue_one(1, -1);
    queue_one(21845, -21846);
    drain();
    // switch to power mode in the middle of the frame
    write_config(spb_pkg::MODE_POWER, RATE_MAX);
    queue_one(-32768, -32768);
    queue_one(0, 0);
    queue_one(2, 2);
    queue_one(7, 7);
    queue_one(15, 15);
    queue_one(15, 16);
    queue_one(32767, 32767);
    queue_one(-21846, 21845);
    queue_one(1, 0);
    queue_one(0, 1);
    queue_one(-1, 0);
    queue_one(0, -1);
    drain();

    total = 25;
    phase = 0;
    while (total < 1000) begin
      case (phase % 4)
        0: rate = '0;
        1: rate = RATE_MAX;
        2: rate = spb_pkg::RATE_W'($urandom);
        default: rate = spb_pkg::RATE_W'($urandom_range(8000, 192000));
      endcase
      n = $urandom_range(30, 180);
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      write_config(phase < 2 ? phase[0] : logic'($urandom_range(0, 1)), rate);
      queue_random(n);
      drain();
      total += n;
      phase++;
    end

    // closing stretch with no idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_config(spb_pkg::MODE_ROOT, spb_pkg::RATE_W'($urandom));
    queue_random(100);
    drain();
    repeat (40) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
